// ===== hw/rtl/eadp_pkg.sv =====
// ----------------------------------------------------------------------------
// eadp_pkg
// Shared constants, codes and controller/datapath signal groups for the
// direction-aware next-block prefetch policy.
// ----------------------------------------------------------------------------
`default_nettype none

package eadp_pkg;

    localparam int unsigned MAX_BLOCKS_DEF  = 8;
    localparam int unsigned BLOCK_BYTES_DEF = 2097152;

    localparam int unsigned LEN_W = 25;
    localparam int unsigned CFG_W = 64;

    localparam logic [7:0]  EPOCH_DEPTH_RST = 8'd8;
    localparam logic [63:0] ALLOC_FLOOR_RST = 64'd4000000000;

    // event kinds
    localparam logic [1:0] FUNC_ALLOC = 2'd0;
    localparam logic [1:0] FUNC_SYNC  = 2'd1;
    localparam logic [1:0] FUNC_FAULT = 2'd2;

    // request sources
    localparam logic [1:0] SRC_EPOCH = 2'd0;
    localparam logic [1:0] SRC_DRAIN = 2'd1;
    localparam logic [1:0] SRC_DIR   = 2'd2;

    // configuration register indexes
    localparam logic CFG_EPOCH_DEPTH = 1'b0;
    localparam logic CFG_ALLOC_FLOOR = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_TGT,
        S_DECIDE,
        S_SYNC,
        S_DRAIN,
        S_DIR
    } t_state;

    typedef struct packed {
        logic       capture;
        logic       eval;
        logic       tgt;
        logic       alloc_upd;
        logic       sync_pend;
        logic       fault_upd;
        logic       drain_step;
        logic       load;
        logic       load_last;
        logic [1:0] load_src;
    } t_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       alloc_take;
        logic       sync_emit;
        logic       sync_pend;
        logic       drain_ok;
        logic       drain_more;
        logic       dir_emit;
        logic       out_free;
    } t_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/eadp_ctrl.sv =====
// ----------------------------------------------------------------------------
// eadp_ctrl
// Sequencer: takes one item, steps the datapath through evaluation and
// decision, then issues the result items one per free output slot.
// ----------------------------------------------------------------------------
`default_nettype none

module eadp_ctrl
    import eadp_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_dir, n_dir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dir   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dir   <= n_dir;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_dir      = r_dir;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_TGT;
            end
            S_TGT: begin
                o_cmd.tgt = 1'b1;
                n_state   = S_DECIDE;
            end
            S_DECIDE: begin
                n_state = S_IDLE;
                case (i_stat.func)
                    FUNC_ALLOC: begin
                        o_cmd.alloc_upd = i_stat.alloc_take;
                    end
                    FUNC_SYNC: begin
                        o_cmd.sync_pend = i_stat.sync_pend;
                        if (i_stat.sync_emit) begin
                            n_state = S_SYNC;
                        end
                    end
                    FUNC_FAULT: begin
                        o_cmd.fault_upd = 1'b1;
                        n_dir           = i_stat.dir_emit;
                        if (i_stat.drain_ok) begin
                            n_state = S_DRAIN;
                        end else if (i_stat.dir_emit) begin
                            n_state = S_DIR;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SYNC: begin
                if (i_stat.out_free) begin
                    o_cmd.load      = 1'b1;
                    o_cmd.load_last = 1'b1;
                    o_cmd.load_src  = SRC_EPOCH;
                    n_state         = S_IDLE;
                end
            end
            S_DRAIN: begin
                if (i_stat.out_free) begin
                    o_cmd.load       = 1'b1;
                    o_cmd.load_last  = !i_stat.drain_more && !r_dir;
                    o_cmd.load_src   = SRC_DRAIN;
                    o_cmd.drain_step = 1'b1;
                    if (!i_stat.drain_more) begin
                        n_state = r_dir ? S_DIR : S_IDLE;
                    end
                end
            end
            S_DIR: begin
                if (i_stat.out_free) begin
                    o_cmd.load      = 1'b1;
                    o_cmd.load_last = 1'b1;
                    o_cmd.load_src  = SRC_DIR;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/eadp_dp.sv =====
// ----------------------------------------------------------------------------
// eadp_dp
// Datapath: configuration, tensor and history state, staged evaluation of
// one event, drain counters and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module eadp_dp
    import eadp_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS  = MAX_BLOCKS_DEF,
    parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire                i_cfg_index,
    input  wire  [CFG_W-1:0]   i_cfg_data,
    input  wire  [1:0]         i_func,
    input  wire  [31:0]        i_owner_id,
    input  wire  [63:0]        i_alloc_size,
    input  wire  [63:0]        i_alloc_addr,
    input  wire  [63:0]        i_fault_end,
    input  wire  [63:0]        i_block_space,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  wire                i_out_ready,
    output logic               o_out_valid,
    output logic [63:0]        o_req_space,
    output logic [63:0]        o_req_addr,
    output logic [LEN_W-1:0]   o_req_length,
    output logic [1:0]         o_source,
    output logic               o_last
);

    localparam int unsigned CNT_W   = $clog2(MAX_BLOCKS + 1);
    localparam logic [63:0] BLOCK64 = 64'(BLOCK_BYTES);

    // configuration
    logic [7:0]  r_epoch_depth;
    logic [63:0] r_alloc_floor;

    // policy state
    logic [63:0]      r_tensor_base;
    logic [63:0]      r_tensor_bytes;
    logic [31:0]      r_tensor_owner;
    logic [63:0]      r_known_space;
    logic             r_pending_flag;
    logic [CNT_W-1:0] r_pending_blocks;
    logic [63:0]      r_older_end;
    logic [63:0]      r_newer_end;
    logic [63:0]      r_previous_target;

    // captured item
    logic [1:0]  r_func;
    logic [31:0] r_owner_id;
    logic [63:0] r_alloc_size;
    logic [63:0] r_alloc_addr;
    logic [63:0] r_fault_end;
    logic [63:0] r_block_space;

    // evaluation stage
    logic             r_alloc_take;
    logic             r_sync_ok;
    logic [CNT_W-1:0] r_lim;
    logic [63:0]      r_wanted;
    logic             r_has_block;
    logic             r_shift;
    logic             r_dir_pre;
    logic [63:0]      r_d1;
    logic [63:0]      r_d2;
    logic [CNT_W-1:0] r_dblocks;

    // target stage
    logic [63:0] r_target;
    logic        r_dir_cond;
    logic [63:0] r_len_sync;

    // drain
    logic [63:0]      r_rem;
    logic [63:0]      r_daddr;
    logic [CNT_W-1:0] r_dcnt;

    logic [CNT_W-1:0] lim_c;
    logic             out_free;
    logic             rem_big;
    logic [63:0]      drain_len;

    always_comb begin
        if (r_epoch_depth == 8'd0) begin
            lim_c = CNT_W'(1);
        end else if (r_epoch_depth > 8'(MAX_BLOCKS)) begin
            lim_c = CNT_W'(MAX_BLOCKS);
        end else begin
            lim_c = CNT_W'(r_epoch_depth);
        end
    end

    assign out_free  = !o_out_valid || i_out_ready;
    assign rem_big   = r_rem > BLOCK64;
    assign drain_len = rem_big ? BLOCK64 : r_rem;

    always_comb begin
        o_stat            = '0;
        o_stat.func       = r_func;
        o_stat.alloc_take = r_alloc_take;
        o_stat.sync_emit  = r_sync_ok && (r_len_sync != '0) && (r_known_space != '0);
        o_stat.sync_pend  = r_sync_ok && (r_len_sync != '0) && (r_known_space == '0);
        o_stat.drain_ok   = r_pending_flag && (r_tensor_base != '0)
                            && (r_tensor_bytes != '0)
                            && (r_has_block || (r_known_space != '0));
        o_stat.drain_more = rem_big && (r_dcnt > CNT_W'(1));
        o_stat.dir_emit   = r_dir_cond && (r_target != r_previous_target);
        o_stat.out_free   = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch_depth <= EPOCH_DEPTH_RST;
            r_alloc_floor <= ALLOC_FLOOR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EPOCH_DEPTH: r_epoch_depth <= i_cfg_data[7:0];
                CFG_ALLOC_FLOOR: r_alloc_floor <= i_cfg_data;
                default:         r_alloc_floor <= r_alloc_floor;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tensor_base     <= '0;
            r_tensor_bytes    <= '0;
            r_tensor_owner    <= '0;
            r_known_space     <= '0;
            r_pending_flag    <= 1'b0;
            r_pending_blocks  <= '0;
            r_older_end       <= '0;
            r_newer_end       <= '0;
            r_previous_target <= '0;
        end else begin
            if (i_cmd.alloc_upd) begin
                r_tensor_base    <= r_alloc_addr;
                r_tensor_bytes   <= r_alloc_size;
                r_tensor_owner   <= r_owner_id;
                r_known_space    <= '0;
                r_pending_flag   <= 1'b0;
                r_pending_blocks <= r_lim;
            end
            if (i_cmd.sync_pend) begin
                r_pending_blocks <= r_lim;
                r_pending_flag   <= 1'b1;
            end
            if (i_cmd.fault_upd) begin
                if (r_has_block) begin
                    r_known_space <= r_block_space;
                end
                if (o_stat.drain_ok) begin
                    r_pending_flag <= 1'b0;
                end
                if (r_shift) begin
                    r_older_end <= r_newer_end;
                    r_newer_end <= r_fault_end;
                end
                if (o_stat.dir_emit) begin
                    r_previous_target <= r_target;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func        <= i_func;
            r_owner_id    <= i_owner_id;
            r_alloc_size  <= i_alloc_size;
            r_alloc_addr  <= i_alloc_addr;
            r_fault_end   <= i_fault_end;
            r_block_space <= i_block_space;
        end
        if (i_cmd.eval) begin
            r_alloc_take <= !(r_alloc_size < r_alloc_floor) && (r_alloc_addr != '0)
                            && ((r_tensor_owner == '0) || (r_tensor_owner == r_owner_id))
                            && ((r_tensor_base == '0) || (r_alloc_size >= r_tensor_bytes));
            r_sync_ok    <= (r_tensor_base != '0) && (r_tensor_owner != '0)
                            && (r_tensor_owner == r_owner_id);
            r_lim        <= lim_c;
            r_wanted     <= 64'(lim_c) * BLOCK64;
            r_has_block  <= (r_fault_end != '0) && (r_block_space != '0);
            r_shift      <= (r_fault_end != '0) && (r_block_space != '0)
                            && (r_fault_end != r_newer_end);
            r_dir_pre    <= (r_fault_end != '0) && (r_block_space != '0)
                            && (r_fault_end != r_newer_end)
                            && (r_older_end != '0) && (r_newer_end != '0);
            r_d1         <= r_newer_end - r_older_end;
            r_d2         <= r_fault_end - r_newer_end;
            r_dblocks    <= ((r_pending_blocks == '0) || (r_pending_blocks > lim_c))
                            ? lim_c : r_pending_blocks;
        end
        if (i_cmd.tgt) begin
            r_target   <= r_d2[63] ? (r_fault_end - BLOCK64) : (r_fault_end + 64'd1);
            r_dir_cond <= r_dir_pre && (r_d1 != '0) && (r_d2 != '0)
                          && (r_d1[63] == r_d2[63]);
            r_len_sync <= (r_tensor_bytes < r_wanted) ? r_tensor_bytes : r_wanted;
        end
        if (i_cmd.fault_upd) begin
            r_rem   <= r_tensor_bytes;
            r_daddr <= r_tensor_base;
            r_dcnt  <= r_dblocks;
        end else if (i_cmd.drain_step) begin
            r_rem   <= r_rem - BLOCK64;
            r_daddr <= r_daddr + BLOCK64;
            r_dcnt  <= r_dcnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_source <= i_cmd.load_src;
            o_last   <= i_cmd.load_last;
            case (i_cmd.load_src)
                SRC_EPOCH: begin
                    o_req_space  <= r_known_space;
                    o_req_addr   <= r_tensor_base;
                    o_req_length <= r_len_sync[LEN_W-1:0];
                end
                SRC_DRAIN: begin
                    o_req_space  <= r_known_space;
                    o_req_addr   <= r_daddr;
                    o_req_length <= drain_len[LEN_W-1:0];
                end
                default: begin
                    o_req_space  <= r_block_space;
                    o_req_addr   <= r_target;
                    o_req_length <= BLOCK64[LEN_W-1:0];
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/epoch_and_direction_prefetch_policy.sv =====
// ----------------------------------------------------------------------------
// epoch_and_direction_prefetch_policy
// Event-driven prefetch policy: epoch prefix, pending drain and
// direction-aware next-block migrate requests.
//
// Input channel (i_in_valid / o_in_ready) takes one event item: allocation,
// sync or fault. The block works on one item at a time; o_in_ready is high
// only while no item is in progress.
// Output channel (o_out_valid / i_out_ready) gives zero to MAX_BLOCKS + 1
// migrate request items per event; o_last marks the final one.
// Timing: an item reaches its decision after the evaluation and target steps,
// then one result item is loaded per cycle while the output register is free.
// An event with no result frees the input at its decision; one with results
// frees it when its last result is loaded.
// The output register lets the next item be accepted while the last result
// waits; a stalled receiver holds further results and so the next item.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect on
// the following edge and belong to idle periods.
// Reset (i_rst_n low, synchronous) restores the register defaults, clears
// all tracked tensor, pending and history state and empties the output.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_and_direction_prefetch_policy
    import eadp_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS  = MAX_BLOCKS_DEF,
    parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire               i_cfg_index,
    input  wire  [CFG_W-1:0]  i_cfg_data,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire  [1:0]        i_func,
    input  wire  [31:0]       i_owner_id,
    input  wire  [63:0]       i_alloc_size,
    input  wire  [63:0]       i_alloc_addr,
    input  wire  [63:0]       i_fault_end,
    input  wire  [63:0]       i_block_space,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output logic [63:0]       o_req_space,
    output logic [63:0]       o_req_addr,
    output logic [LEN_W-1:0]  o_req_length,
    output logic [1:0]        o_source,
    output logic              o_last
);

    t_cmd  cmd;
    t_stat stat;

    eadp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    eadp_dp #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_func        (i_func),
        .i_owner_id    (i_owner_id),
        .i_alloc_size  (i_alloc_size),
        .i_alloc_addr  (i_alloc_addr),
        .i_fault_end   (i_fault_end),
        .i_block_space (i_block_space),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_req_space   (o_req_space),
        .o_req_addr    (o_req_addr),
        .o_req_length  (o_req_length),
        .o_source      (o_source),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire
